// ===== hw/rtl/cbp_pkg.sv =====
// Shared types, register map, codes and weight-curve tables for the colour balance block.
package cbp_pkg;

    localparam int unsigned NUM_CHAN   = 3;
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned GAIN_W     = 8;
    localparam int unsigned WEIGHT_W   = 18;   // signed Q2.16
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned PROD_W     = GAIN_W + WEIGHT_W;
    localparam int unsigned LUT_DEPTH  = 256;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    // register indexes (word address)
    localparam logic [1:0] REG_RED_GAIN   = 2'd0;
    localparam logic [1:0] REG_GREEN_GAIN = 2'd1;
    localparam logic [1:0] REG_BLUE_GAIN  = 2'd2;
    localparam logic [1:0] REG_TONE_RANGE = 2'd3;

    // tone range codes
    localparam logic [1:0] TONE_SHADOWS    = 2'd0;
    localparam logic [1:0] TONE_MIDTONES   = 2'd1;
    localparam logic [1:0] TONE_HIGHLIGHTS = 2'd2;

    typedef enum logic [1:0] {
        CURVE_QUAD,
        CURVE_RAT,
        CURVE_NONE
    } curve_t;

    typedef struct packed {
        logic [NUM_CHAN-1:0][GAIN_W-1:0] gain;
        logic [1:0]                      tone_range;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic [PIX_W-1:0]  idx;
        logic [GAIN_W-1:0] gain;
        curve_t            curve;
    } chan_cmd_t;

    typedef chan_cmd_t [NUM_CHAN-1:0] pix_cmd_t;

    typedef logic signed [WEIGHT_W-1:0] lut_t [LUT_DEPTH];

    // shift-and-subtract quotient for table construction; num >= 0, den > 0
    function automatic longint const_udiv(input longint num, input longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            r = (r << 1) | ((num >> b) & 64'sd1);
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // 0.667 * (1 - ((x-127)/127)^2), Q2.16, nearest, ties away from zero
    function automatic lut_t build_quad_lut();
        lut_t   t;
        longint d;
        longint num;
        longint mag;
        longint q;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            d   = longint'(i) - 64'sd127;
            num = 64'sd667 * (64'sd16129 - d * d) * 64'sd65536;
            mag = (num < 0) ? -num : num;
            q   = const_udiv(2 * mag + 64'sd16129000, 2 * 64'sd16129000);
            t[i] = WEIGHT_W'((num < 0) ? -q : q);
        end
        return t;
    endfunction

    // 1.075 - 1/(x/16 + 1), Q2.16, nearest; always positive
    function automatic lut_t build_rat_lut();
        lut_t   t;
        longint num;
        longint den;
        longint q;
        for (int i = 0; i < LUT_DEPTH; i++) begin
            den = 64'sd1000 * (longint'(i) + 64'sd16);
            num = (64'sd1075 * (longint'(i) + 64'sd16) - 64'sd16000) * 64'sd65536;
            q   = const_udiv(2 * num + den, 2 * den);
            t[i] = WEIGHT_W'(q);
        end
        return t;
    endfunction

    localparam lut_t QUAD_LUT = build_quad_lut();
    localparam lut_t RAT_LUT  = build_rat_lut();

endpackage

// ===== hw/rtl/cbp_front.sv =====
// Front end: picks the weight curve and table index for each channel of an incoming pixel.
module cbp_front import cbp_pkg::*; (
    input  cfg_t                  cfg,
    input  logic [PIX_W-1:0]      red_in,
    input  logic [PIX_W-1:0]      green_in,
    input  logic [PIX_W-1:0]      blue_in,
    output pix_cmd_t              cmd
);

    logic [NUM_CHAN-1:0][PIX_W-1:0] pix;
    logic [NUM_CHAN-1:0]            gain_pos;

    assign pix[0] = red_in;
    assign pix[1] = green_in;
    assign pix[2] = blue_in;

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            gain_pos[c]    = !cfg.gain[c][GAIN_W-1] && (cfg.gain[c] != '0);
            cmd[c].pix     = pix[c];
            cmd[c].gain    = cfg.gain[c];
            cmd[c].idx     = pix[c];
            cmd[c].curve   = CURVE_NONE;
            case (cfg.tone_range)
                TONE_SHADOWS: begin
                    if (gain_pos[c]) begin
                        cmd[c].curve = CURVE_QUAD;
                    end else begin
                        // darken curve mirrored about mid grey
                        cmd[c].curve = CURVE_RAT;
                        cmd[c].idx   = ~pix[c];
                    end
                end
                TONE_MIDTONES: begin
                    cmd[c].curve = CURVE_QUAD;
                end
                TONE_HIGHLIGHTS: begin
                    cmd[c].curve = gain_pos[c] ? CURVE_RAT : CURVE_QUAD;
                end
                default: begin
                    cmd[c].curve = CURVE_NONE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/cbp_queue.sv =====
// Short command queue between front and back end.
module cbp_queue import cbp_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  pix_cmd_t in_cmd,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_cmd_t out_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pix_cmd_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== hw/rtl/cbp_back.sv =====
// Back end: curve lookup, gain multiply, truncate, add and clamp, three register stages.
module cbp_back import cbp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  pix_cmd_t         cmd,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] red_out,
    output logic [PIX_W-1:0] green_out,
    output logic [PIX_W-1:0] blue_out
);

    // stage valids
    logic va_reg, vb_reg, vc_reg;
    logic adv_a, adv_b, adv_c;

    // stage A: weight looked up
    logic signed [NUM_CHAN-1:0][WEIGHT_W-1:0] w_next;
    logic [NUM_CHAN-1:0][WEIGHT_W-1:0]        w_reg;
    logic [NUM_CHAN-1:0][GAIN_W-1:0]          gain_a_reg;
    logic [NUM_CHAN-1:0][PIX_W-1:0]           pix_a_reg;

    // stage B: product
    logic [NUM_CHAN-1:0][PROD_W-1:0]          prod_next;
    logic [NUM_CHAN-1:0][PROD_W-1:0]          prod_reg;
    logic [NUM_CHAN-1:0][PIX_W-1:0]           pix_b_reg;

    // stage C: result
    logic [NUM_CHAN-1:0][PROD_W-1:0]          biased;
    logic [NUM_CHAN-1:0][PIX_W+1:0]           quot;
    logic [NUM_CHAN-1:0][PIX_W+2:0]           sum;
    logic [NUM_CHAN-1:0][PIX_W-1:0]           res_next;
    logic [NUM_CHAN-1:0][PIX_W-1:0]           res_reg;

    assign adv_c     = !vc_reg || out_ready;
    assign adv_b     = !vb_reg || adv_c;
    assign adv_a     = !va_reg || adv_b;
    assign cmd_ready = adv_a;
    assign out_valid = vc_reg;

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            case (cmd[c].curve)
                CURVE_QUAD: w_next[c] = QUAD_LUT[cmd[c].idx];
                CURVE_RAT:  w_next[c] = RAT_LUT[cmd[c].idx];
                default:    w_next[c] = '0;
            endcase
            prod_next[c] = PROD_W'($signed(gain_a_reg[c]) * $signed(w_reg[c]));
            // truncate toward zero: bias negative products before the shift
            biased[c] = prod_reg[c]
                        + {{(PROD_W-FRAC_W){1'b0}}, {FRAC_W{prod_reg[c][PROD_W-1]}}};
            quot[c]   = biased[c][PROD_W-1:FRAC_W];
            sum[c]    = {3'b000, pix_b_reg[c]} + {quot[c][PIX_W+1], quot[c]};
            if (sum[c][PIX_W+2]) begin
                res_next[c] = '0;
            end else if (sum[c][PIX_W+1:PIX_W] != 2'b00) begin
                res_next[c] = '1;
            end else begin
                res_next[c] = sum[c][PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (adv_a) va_reg <= cmd_valid;
            if (adv_b) vb_reg <= va_reg;
            if (adv_c) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                w_reg[c]      <= w_next[c];
                gain_a_reg[c] <= cmd[c].gain;
                pix_a_reg[c]  <= cmd[c].pix;
            end
        end
        if (adv_b) begin
            prod_reg  <= prod_next;
            pix_b_reg <= pix_a_reg;
        end
        if (adv_c) begin
            res_reg <= res_next;
        end
    end

    assign red_out   = res_reg[0];
    assign green_out = res_reg[1];
    assign blue_out  = res_reg[2];

endmodule

// ===== hw/rtl/color_balance_pixel_top.sv =====
// Top level of the colour balance block: APB register file, front end, queue and back end.
//
// Pixels arrive on the s_ channel (red_in, green_in, blue_in) and leave balanced on the
// m_ channel; both are valid/ready, a transfer taking place when valid and ready are high.
// Throughput: one pixel per clock while m_ready is high, set by the three-stage back end
// (curve table lookup, gain multiply, truncate/add/clamp), each stage moving on whenever
// the one after it is free. A pixel taken in goes into the queue, then the stage registers.
// The front end classifies each channel (tone range and sign of gain pick the curve
// and table index) and writes the command into a QUEUE_DEPTH-entry queue; s_ready is
// high while the queue has room.
// When the receiver stalls, the output register holds, the back end stages fill, then
// the queue; up to QUEUE_DEPTH + 3 pixels may be in flight before s_ready drops.
// Registers on the APB port: 0x0 red gain, 0x4 green gain, 0x8 blue gain (8-bit
// signed), 0xC tone range (0 shadows, 1 midtones, 2 highlights, 3 pass-through).
// Write them only while no pixel is in flight. pready is tied high.
// Reset (aresetn low, synchronous) empties queue and pipeline and sets gains to 0,
// tone range to midtones; no clearing pass is needed.
module color_balance_pixel_top import cbp_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // APB
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // pixel in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_red_in,
    input  logic [PIX_W-1:0]      s_green_in,
    input  logic [PIX_W-1:0]      s_blue_in,
    // pixel out
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_red_out,
    output logic [PIX_W-1:0]      m_green_out,
    output logic [PIX_W-1:0]      m_blue_out
);

    localparam int unsigned INFLIGHT_MAX = QUEUE_DEPTH + 3;
    localparam int unsigned INFLIGHT_W   = $clog2(INFLIGHT_MAX + 1);

    cfg_t             cfg_reg;
    logic             cfg_wr;
    logic [1:0]       reg_idx;
    pix_cmd_t         front_cmd;
    pix_cmd_t         queue_cmd;
    logic             queue_valid;
    logic             back_ready;

    logic [INFLIGHT_W-1:0] inflight_reg, inflight_next;

    // ---------------- register file ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain       <= '0;
            cfg_reg.tone_range <= TONE_MIDTONES;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_RED_GAIN:   cfg_reg.gain[0]    <= pwdata[GAIN_W-1:0];
                REG_GREEN_GAIN: cfg_reg.gain[1]    <= pwdata[GAIN_W-1:0];
                REG_BLUE_GAIN:  cfg_reg.gain[2]    <= pwdata[GAIN_W-1:0];
                REG_TONE_RANGE: cfg_reg.tone_range <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RED_GAIN:   prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.gain[0]};
            REG_GREEN_GAIN: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.gain[1]};
            REG_BLUE_GAIN:  prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg_reg.gain[2]};
            REG_TONE_RANGE: prdata = {{(APB_DATA_W-2){1'b0}}, cfg_reg.tone_range};
            default:        prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    cbp_front u_front (
        .cfg      (cfg_reg),
        .red_in   (s_red_in),
        .green_in (s_green_in),
        .blue_in  (s_blue_in),
        .cmd      (front_cmd)
    );

    cbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (back_ready),
        .out_cmd   (queue_cmd)
    );

    cbp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_valid),
        .cmd_ready (back_ready),
        .cmd       (queue_cmd),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .red_out   (m_red_out),
        .green_out (m_green_out),
        .blue_out  (m_blue_out)
    );

    // ---------------- checks ----------------
    // pixels taken in but not yet transferred out
    always_comb begin
        inflight_next = inflight_reg;
        if ((s_valid && s_ready) && !(m_valid && m_ready)) begin
            inflight_next = inflight_reg + 1'b1;
        end else if (!(s_valid && s_ready) && (m_valid && m_ready)) begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    a_no_phantom_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (inflight_reg != '0))
        else $error("result offered with no pixel in flight");

    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= INFLIGHT_W'(INFLIGHT_MAX))
        else $error("more pixels in flight than queue and pipeline hold");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (inflight_reg == '0) |-> s_ready)
        else $error("input stalled while block is empty");

    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result offered straight after reset");

endmodule

// ===== test/tb_color_balance_pixel_top.sv =====
// Self-checking testbench for the colour balance pixel block: stream stimulus, prediction, checks.
`timescale 1ns / 100ps

module tb_color_balance_pixel_top;
    import cbp_pkg::*;

    // Tone range 3 is unused by the block: every channel passes through unchanged
    localparam logic [1:0] TONE_BYPASS = 2'd3;
    localparam int unsigned CLK_PERIOD  = 20;
    localparam int unsigned LONG_STALL  = 160;   // receiver hold-off, in cycles
    localparam int unsigned DRAIN_WAIT  = 8;     // allow some slack before the final report
    localparam int unsigned RAND_PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 50;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid  = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_red_in   = '0;
    logic [PIX_W-1:0]      s_green_in = '0;
    logic [PIX_W-1:0]      s_blue_in  = '0;
    logic                  m_valid;
    logic                  m_ready  = 1'b0;
    logic [PIX_W-1:0]      m_red_out;
    logic [PIX_W-1:0]      m_green_out;
    logic [PIX_W-1:0]      m_blue_out;

    // Testbench copy of the register file, updated on every APB write
    logic [GAIN_W-1:0] gain_cfg [NUM_CHAN];
    logic [1:0]        tone_cfg;

    pixel_t pixel_backlog[$];     // pixels waiting to be offered on the s_ channel
    pixel_t balanced_due[$];      // balanced pixels still owed by the m_ channel
    pixel_t next_pixel;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    int unsigned error_count    = 0;
    bit          hold_req       = 1'b0;
    bit          in_taken       = 1'b0;

    color_balance_pixel_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: weight curves in Q2.16, rounded to nearest with ties
    // away from zero, then gain * weight truncated toward zero and clamped.
    // ------------------------------------------------------------------
    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    // 0.667 * (1 - ((x - 127) / 127)^2); goes slightly negative at x = 255
    function automatic longint bell_weight(input longint x);
        longint d;
        d = x - 127;
        return div_nearest(667 * (16129 - d * d) * 65536, 64'sd16129000);
    endfunction

    // 1.075 - 1 / (x / 16 + 1)
    function automatic longint knee_weight(input longint x);
        return div_nearest((1075 * (x + 16) - 16000) * 65536, 1000 * (x + 16));
    endfunction

    function automatic logic [PIX_W-1:0] balance_channel(input logic [PIX_W-1:0] x,
                                                         input logic [GAIN_W-1:0] gain,
                                                         input logic [1:0] tone);
        longint xv;
        longint gv;
        longint w;
        longint y;
        xv = longint'(x);
        gv = longint'($signed(gain));
        case (tone)
            TONE_SHADOWS: begin
                // darkening shadows uses the knee curve mirrored about mid-scale
                w = (gv > 0) ? bell_weight(xv) : knee_weight(255 - xv);
            end
            TONE_MIDTONES: begin
                w = bell_weight(xv);
            end
            TONE_HIGHLIGHTS: begin
                w = (gv > 0) ? knee_weight(xv) : bell_weight(xv);
            end
            default: begin
                return x;
            end
        endcase
        y = xv + (gv * w) / 65536;   // signed division truncates toward zero
        if (y < 0) y = 0;
        if (y > 255) y = 255;
        return PIX_W'(y);
    endfunction

    function automatic pixel_t balance_pixel(input pixel_t p);
        pixel_t r;
        r.red   = balance_channel(p.red,   gain_cfg[REG_RED_GAIN],   tone_cfg);
        r.green = balance_channel(p.green, gain_cfg[REG_GREEN_GAIN], tone_cfg);
        r.blue  = balance_channel(p.blue,  gain_cfg[REG_BLUE_GAIN],  tone_cfg);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: new payload at the falling edge, once the previous
    // transfer has completed (flagged by the rising-edge monitor).
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            in_taken = 1'b0;
            if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_pixel = pixel_backlog.pop_front();
                s_valid    <= 1'b1;
                s_red_in   <= next_pixel.red;
                s_green_in <= next_pixel.green;
                s_blue_in  <= next_pixel.blue;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request to fill the block up
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_STALL;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic next_due_check(input pixel_t want);
        if (m_red_out !== want.red || m_green_out !== want.green
                || m_blue_out !== want.blue) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: pixel mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                         $realtime, want.red, want.green, want.blue,
                         m_red_out, m_green_out, m_blue_out);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: input transfers queue a prediction, output transfers are
    // checked against the oldest one.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                in_taken = 1'b1;
                balanced_due.push_back(balance_pixel('{s_red_in, s_green_in, s_blue_in}));
            end
            if (m_valid && m_ready) begin
                if (balanced_due.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected output r=%0d g=%0d b=%0d", $realtime,
                                 m_red_out, m_green_out, m_blue_out);
                end else begin
                    next_due_check(balanced_due.pop_front());
                end
            end
        end
    end

    // APB write followed by a read back of the same register
    task automatic set_register(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] mask;
        mask = (idx == REG_TONE_RANGE) ? APB_DATA_W'(2'b11) : APB_DATA_W'({GAIN_W{1'b1}});
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_TONE_RANGE)
            tone_cfg = value[1:0];
        else
            gain_cfg[idx] = value[GAIN_W-1:0];
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if ((prdata & mask) !== (value & mask)) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: register %0d read back 0x%0h, expected 0x%0h", $realtime,
                         idx, prdata & mask, value & mask);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_balance(input logic [1:0] tone, input logic signed [GAIN_W-1:0] r,
                               input logic signed [GAIN_W-1:0] g,
                               input logic signed [GAIN_W-1:0] b);
        set_register(REG_RED_GAIN,   APB_DATA_W'(r));
        set_register(REG_GREEN_GAIN, APB_DATA_W'(g));
        set_register(REG_BLUE_GAIN,  APB_DATA_W'(b));
        set_register(REG_TONE_RANGE, APB_DATA_W'(tone));
    endtask

    task automatic queue_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                               input logic [PIX_W-1:0] b);
        pixel_backlog.push_back('{r, g, b});
    endtask

    // Extremes, mid-scale either side of the curve peak, and near-extremes
    task automatic queue_edge_pixels();
        queue_pixel(8'd0,   8'd255, 8'd127);
        queue_pixel(8'd255, 8'd0,   8'd128);
        queue_pixel(8'd1,   8'd254, 8'd64);
        queue_pixel(8'd128, 8'd127, 8'd200);
    endtask

    // Block is idle once nothing is queued, offered or owed
    task automatic drain();
        while (pixel_backlog.size() != 0 || s_valid || balanced_due.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return GAIN_W'(-100);
            1: return GAIN_W'(100);
            2: return '0;
            3: return GAIN_W'(-128);
            4: return GAIN_W'(127);
            default: return GAIN_W'(int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: directed groups, then random phases with rotating idling
    // ------------------------------------------------------------------
    initial begin
        gain_cfg[REG_RED_GAIN]   = '0;
        gain_cfg[REG_GREEN_GAIN] = '0;
        gain_cfg[REG_BLUE_GAIN]  = '0;
        tone_cfg                 = TONE_MIDTONES;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero gain, every channel passes unchanged
        queue_pixel(8'd0, 8'd255, 8'd128);
        queue_pixel(8'd255, 8'd0, 8'd127);
        drain();

        // each tone range with brightening and darkening gains
        set_balance(TONE_SHADOWS, 8'sd100, -8'sd100, 8'sd0);
        queue_edge_pixels();
        drain();
        set_balance(TONE_MIDTONES, -8'sd100, 8'sd100, 8'sd127);
        queue_edge_pixels();
        drain();
        set_balance(TONE_HIGHLIGHTS, 8'sd100, -8'sd100, -8'sd128);
        queue_edge_pixels();
        drain();
        // gains outside the nominal range, and the smallest darkening gain
        set_balance(TONE_SHADOWS, 8'sd127, -8'sd128, -8'sd1);
        queue_edge_pixels();
        drain();
        // unused tone range: pass-through whatever the gains
        set_balance(TONE_BYPASS, 8'sd100, -8'sd100, 8'sd50);
        queue_pixel(8'd0, 8'd255, 8'd127);
        queue_pixel(8'd255, 8'd0, 8'd1);
        queue_pixel(8'd170, 8'd85, 8'd254);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_balance((ph == RAND_PHASES - 1) ? TONE_BYPASS : 2'(ph % 3),
                        pick_gain(), pick_gain(), pick_gain());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            // back-pressure phase: receiver holds off while pixels keep coming
            if (ph == 4) begin
                @(posedge aclk);
                hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) queue_pixel(pick_level(), pick_level(), pick_level());
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0 && balanced_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cbp_pkg.sv
hw/rtl/cbp_front.sv
hw/rtl/cbp_queue.sv
hw/rtl/cbp_back.sv
hw/rtl/color_balance_pixel_top.sv
test/tb_color_balance_pixel_top.sv
